@@ sv/hkq_pkg.sv @@
// Shared types, codes and the usage-to-key translation for the HID key queue.
`default_nettype none

package hkq_pkg;

    // item kinds
    localparam logic [1:0] KIND_MOUNT   = 2'd0;
    localparam logic [1:0] KIND_UNMOUNT = 2'd1;
    localparam logic [1:0] KIND_REPORT  = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    // configuration register indexes
    localparam logic [0:0] CFG_ENTER = 1'b0;
    localparam logic [0:0] CFG_F10   = 1'b1;

    localparam logic [7:0] ENTER_RESET    = 8'd13;
    localparam logic [7:0] F10_RESET      = 8'd138;
    localparam logic [7:0] SHIFT_MASK     = 8'h22;
    localparam logic [6:0] MIN_REPORT_LEN = 7'd8;

    localparam int SLOTS     = 6;
    localparam int BANKS     = 8;
    localparam int BANK_BITS = 3;

    localparam logic [7:0] KEY_ESC   = 8'h1B;
    localparam logic [7:0] KEY_BKSP  = 8'h08;
    localparam logic [7:0] KEY_TAB   = 8'h09;
    localparam logic [7:0] KEY_SPACE = 8'h20;
    localparam logic [7:0] KEY_F1    = 8'h81;
    localparam logic [7:0] KEY_INS   = 8'hD1;
    localparam logic [7:0] KEY_HOME  = 8'hD2;
    localparam logic [7:0] KEY_DEL   = 8'hD4;
    localparam logic [7:0] KEY_RIGHT = 8'hB7;
    localparam logic [7:0] KEY_LEFT  = 8'hB4;
    localparam logic [7:0] KEY_DOWN  = 8'hB6;
    localparam logic [7:0] KEY_UP    = 8'hB5;

    typedef struct packed {
        logic       known;
        logic [7:0] code;
    } t_xlat;

    // top row digits, plain "1234567890", shifted "!@#$%^&*()"
    function automatic logic [7:0] digit_char(input logic [3:0] idx, input logic shift);
        logic [7:0] c;
        begin
            case ({shift, idx})
                5'h00: c = 8'h31;  5'h01: c = 8'h32;  5'h02: c = 8'h33;
                5'h03: c = 8'h34;  5'h04: c = 8'h35;  5'h05: c = 8'h36;
                5'h06: c = 8'h37;  5'h07: c = 8'h38;  5'h08: c = 8'h39;
                5'h09: c = 8'h30;
                5'h10: c = 8'h21;  5'h11: c = 8'h40;  5'h12: c = 8'h23;
                5'h13: c = 8'h24;  5'h14: c = 8'h25;  5'h15: c = 8'h5E;
                5'h16: c = 8'h26;  5'h17: c = 8'h2A;  5'h18: c = 8'h28;
                5'h19: c = 8'h29;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // - = [ ] \ (non-US hash) ; ' ` , . /
    function automatic logic [7:0] punct_char(input logic [3:0] idx, input logic shift);
        logic [7:0] c;
        begin
            case ({shift, idx})
                5'h00: c = 8'h2D;  5'h01: c = 8'h3D;  5'h02: c = 8'h5B;
                5'h03: c = 8'h5D;  5'h04: c = 8'h5C;  5'h06: c = 8'h3B;
                5'h07: c = 8'h27;  5'h08: c = 8'h60;  5'h09: c = 8'h2C;
                5'h0A: c = 8'h2E;  5'h0B: c = 8'h2F;
                5'h10: c = 8'h5F;  5'h11: c = 8'h2B;  5'h12: c = 8'h7B;
                5'h13: c = 8'h7D;  5'h14: c = 8'h7C;  5'h16: c = 8'h3A;
                5'h17: c = 8'h22;  5'h18: c = 8'h7E;  5'h19: c = 8'h3C;
                5'h1A: c = 8'h3E;  5'h1B: c = 8'h3F;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic t_xlat translate(input logic [7:0] hid, input logic shift,
                                        input logic [7:0] enter_code,
                                        input logic [7:0] f10_code);
        t_xlat r;
        logic [7:0] off;
        begin
            r   = '{known: 1'b1, code: 8'h00};
            off = 8'h00;
            if (hid >= 8'h04 && hid <= 8'h1D) begin
                off    = hid - 8'h04;
                r.code = (shift ? 8'h41 : 8'h61) + off;
            end else if (hid >= 8'h1E && hid <= 8'h27) begin
                off    = hid - 8'h1E;
                r.code = digit_char(off[3:0], shift);
            end else if (hid >= 8'h2D && hid <= 8'h38 && hid != 8'h32) begin
                off    = hid - 8'h2D;
                r.code = punct_char(off[3:0], shift);
            end else if (hid >= 8'h3A && hid <= 8'h42) begin
                off    = hid - 8'h3A;
                r.code = KEY_F1 + off;
            end else begin
                case (hid)
                    8'h28:   r.code = enter_code;
                    8'h29:   r.code = KEY_ESC;
                    8'h2A:   r.code = KEY_BKSP;
                    8'h2B:   r.code = KEY_TAB;
                    8'h2C:   r.code = KEY_SPACE;
                    8'h43:   r.code = f10_code;
                    8'h49:   r.code = KEY_INS;
                    8'h4A:   r.code = KEY_HOME;
                    8'h4C:   r.code = KEY_DEL;
                    8'h4F:   r.code = KEY_RIGHT;
                    8'h50:   r.code = KEY_LEFT;
                    8'h51:   r.code = KEY_DOWN;
                    8'h52:   r.code = KEY_UP;
                    default: r.known = 1'b0;
                endcase
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/hkq_in_if.sv @@
// Input channel: one mount, unmount, report or read item per handshake.
`default_nettype none

interface hkq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] dev_addr;
    logic [7:0] interface_index;
    logic       is_keyboard;
    logic [6:0] report_length;
    logic [7:0] modifier;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;

    modport source (
        output valid, kind, dev_addr, interface_index, is_keyboard, report_length,
               modifier, key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4,
               key_slot_5,
        input  ready
    );

    modport sink (
        input  valid, kind, dev_addr, interface_index, is_keyboard, report_length,
               modifier, key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4,
               key_slot_5,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/hkq_out_if.sv @@
// Output channel: one popped key (or empty indication) per handshake.
`default_nettype none

interface hkq_out_if;
    logic       valid;
    logic       ready;
    logic       got_key;
    logic [7:0] key_code;

    modport source (
        output valid, got_key, key_code,
        input  ready
    );

    modport sink (
        input  valid, got_key, key_code,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/hkq_ram.sv @@
// Generic single write port RAM with enabled, registered read.
`default_nettype none

module hkq_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/hid_keyboard_report_to_key_queue.sv @@
// Top level: boot keyboard report decoder feeding a key queue.
//
// Usage
//   i_item (valid/ready) carries mount, unmount, report and read items. Only a
//   read item produces a result on o_key: got_key and the popped key_code,
//   or got_key = 0 and key_code = 0 when the queue is empty.
//   i_cfg_we/i_cfg_idx/i_cfg_data write enter_code (0) and f10_code (1); write
//   them only while the block is idle.
// Timing
//   One item per cycle unless o_key stalls or the map is being cleared. An item
//   is registered on acceptance (keyboard map read), processed once the result
//   register can advance, and a read result is then registered for o_key (key RAM read).
//   A report pushes up to six keys at once into an 8-bank key ring, one
//   bank per consecutive queue position, so each bank takes at most one write.
// Reset
//   Synchronous, active low. Queue pointers, previous keycodes and config
//   registers reset at once; the keyboard map RAM is then swept clear,
//   one entry a cycle over all MAX_DEVICES * MAX_INTERFACES entries, while
//   i_item.ready stays low.
// Back-pressure
//   The result register holds while o_key.ready is low; the item in
//   process waits behind it, and i_item.ready drops once that slot is full.
`default_nettype none

module hid_keyboard_report_to_key_queue #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int MAX_DEVICES    = 5,
    parameter int MAX_INTERFACES = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    hkq_in_if.sink          i_item,
    hkq_out_if.source       o_key,
    input  wire logic       i_cfg_we,
    input  wire logic [0:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    localparam int NUM_ITF   = MAX_DEVICES * MAX_INTERFACES;
    localparam int MAP_AW    = (NUM_ITF > 1) ? $clog2(NUM_ITF) : 1;
    // physical ring is a power of two, at least two rows of eight banks;
    // the logical capacity is enforced by the fill count
    localparam int RING      = (QUEUE_DEPTH <= 16) ? 16 : (1 << $clog2(QUEUE_DEPTH));
    localparam int PTR_W     = $clog2(RING);
    localparam int ROW_DEPTH = RING / hkq_pkg::BANKS;
    localparam int ROW_W     = PTR_W - hkq_pkg::BANK_BITS;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH);
    localparam int CMP_W     = CNT_W + 3;
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(QUEUE_DEPTH - 1);
    localparam logic [MAP_AW-1:0] MAP_LAST = MAP_AW'(NUM_ITF - 1);

    // ---------------- configuration ----------------
    logic [7:0] r_enter_code;
    logic [7:0] r_f10_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_code <= hkq_pkg::ENTER_RESET;
            r_f10_code   <= hkq_pkg::F10_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hkq_pkg::CFG_ENTER: r_enter_code <= i_cfg_data;
                hkq_pkg::CFG_F10:   r_f10_code   <= i_cfg_data;
                default:            ;
            endcase
        end
    end

    // ---------------- handshake and flow ----------------
    logic r_clr_busy;
    logic [MAP_AW-1:0] r_clr_addr;
    logic r_s1_valid;
    logic r_out_valid;
    logic adv;
    logic s1_done;
    logic in_fire;

    assign adv          = !r_out_valid || o_key.ready;
    assign s1_done      = r_s1_valid && adv;
    assign i_item.ready = !r_clr_busy && (!r_s1_valid || adv);
    assign in_fire      = i_item.valid && i_item.ready;

    // ---------------- stage 1: input register ----------------
    logic              in_range;
    logic [MAP_AW-1:0] in_slot;

    assign in_range = (i_item.dev_addr < 8'(MAX_DEVICES))
                   && (i_item.interface_index < 8'(MAX_INTERFACES));
    assign in_slot  = MAP_AW'(i_item.dev_addr) * MAP_AW'(MAX_INTERFACES)
                    + MAP_AW'(i_item.interface_index);

    logic [1:0]        r_s1_kind;
    logic              r_s1_in_range;
    logic [MAP_AW-1:0] r_s1_slot;
    logic              r_s1_kbd;
    logic              r_s1_len_ok;
    logic              r_s1_shift;
    logic [7:0]        r_s1_raw [hkq_pkg::SLOTS];
    logic              r_fwd_hit;
    logic              r_fwd_val;

    // map write from the item completing now
    logic map_upd;
    logic map_upd_val;
    logic n_fwd_hit;

    assign map_upd     = s1_done && r_s1_in_range
                      && (r_s1_kind == hkq_pkg::KIND_MOUNT
                          || r_s1_kind == hkq_pkg::KIND_UNMOUNT);
    assign map_upd_val = (r_s1_kind == hkq_pkg::KIND_MOUNT) && r_s1_kbd;
    // the RAM returns old data when read and written at the same edge
    assign n_fwd_hit   = map_upd && in_range && (in_slot == r_s1_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_kind     <= i_item.kind;
            r_s1_in_range <= in_range;
            r_s1_slot     <= in_slot;
            r_s1_kbd      <= i_item.is_keyboard;
            r_s1_len_ok   <= i_item.report_length >= hkq_pkg::MIN_REPORT_LEN;
            r_s1_shift    <= (i_item.modifier & hkq_pkg::SHIFT_MASK) != 8'h00;
            r_s1_raw[0]   <= i_item.key_slot_0;
            r_s1_raw[1]   <= i_item.key_slot_1;
            r_s1_raw[2]   <= i_item.key_slot_2;
            r_s1_raw[3]   <= i_item.key_slot_3;
            r_s1_raw[4]   <= i_item.key_slot_4;
            r_s1_raw[5]   <= i_item.key_slot_5;
            r_fwd_hit     <= n_fwd_hit;
            r_fwd_val     <= map_upd_val;
        end
    end

    // ---------------- keyboard map RAM with clearing sweep ----------------
    logic              map_we;
    logic [MAP_AW-1:0] map_waddr;
    logic              map_wdata;
    logic              map_q;
    logic              map_bit;

    assign map_we    = r_clr_busy || map_upd;
    assign map_waddr = r_clr_busy ? r_clr_addr : r_s1_slot;
    assign map_wdata = !r_clr_busy && map_upd_val;

    hkq_ram #(
        .WIDTH (1),
        .DEPTH (NUM_ITF)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (in_fire),
        .i_raddr (in_slot),
        .o_rdata (map_q)
    );

    assign map_bit = r_fwd_hit ? r_fwd_val : map_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == MAP_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------- stage 2: report decode ----------------
    logic [7:0]       r_prev [hkq_pkg::SLOTS];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic                 do_report;
    hkq_pkg::t_xlat       xl   [hkq_pkg::SLOTS];
    logic [hkq_pkg::SLOTS-1:0] held;
    logic [hkq_pkg::SLOTS-1:0] want;
    logic [hkq_pkg::SLOTS-1:0] take;
    logic [2:0]           rank [hkq_pkg::SLOTS];
    logic [2:0]           acc;
    logic [2:0]           n_push;
    logic [CNT_W-1:0]     free_cnt;

    assign do_report = (r_s1_kind == hkq_pkg::KIND_REPORT) && r_s1_in_range
                    && map_bit && r_s1_len_ok;
    assign free_cnt  = CNT_MAX - r_count;

    always_comb begin
        acc    = 3'd0;
        n_push = 3'd0;
        for (int i = 0; i < hkq_pkg::SLOTS; i++) begin
            held[i] = 1'b0;
            for (int j = 0; j < hkq_pkg::SLOTS; j++) begin
                held[i] = held[i] || (r_prev[j] == r_s1_raw[i]);
            end
            xl[i]   = hkq_pkg::translate(r_s1_raw[i], r_s1_shift, r_enter_code, r_f10_code);
            // usage 0 (none) and 1 (rollover) are skipped
            want[i] = (r_s1_raw[i][7:1] != 7'd0) && !held[i] && xl[i].known;
            rank[i] = acc;
            take[i] = want[i] && (CMP_W'(acc) < CMP_W'(free_cnt));
            acc     = acc + {2'b00, want[i]};
            n_push  = n_push + {2'b00, take[i]};
        end
    end

    // key ring banks: consecutive positions fall in distinct banks
    logic             bank_we    [hkq_pkg::BANKS];
    logic [ROW_W-1:0] bank_waddr [hkq_pkg::BANKS];
    logic [7:0]       bank_wdata [hkq_pkg::BANKS];
    logic             bank_re    [hkq_pkg::BANKS];
    logic [7:0]       bank_q     [hkq_pkg::BANKS];
    logic [2:0]       bank_ofs   [hkq_pkg::BANKS];
    logic [PTR_W-1:0] bank_pos   [hkq_pkg::BANKS];

    logic do_pop;
    logic q_nonempty;

    assign q_nonempty = r_count != '0;
    assign do_pop     = s1_done && (r_s1_kind == hkq_pkg::KIND_READ) && q_nonempty;

    always_comb begin
        for (int b = 0; b < hkq_pkg::BANKS; b++) begin
            bank_ofs[b]   = 3'(b) - r_wr_ptr[2:0];
            bank_pos[b]   = r_wr_ptr + PTR_W'(bank_ofs[b]);
            bank_we[b]    = s1_done && do_report && (bank_ofs[b] < n_push);
            bank_waddr[b] = bank_pos[b][PTR_W-1:hkq_pkg::BANK_BITS];
            bank_wdata[b] = 8'h00;
            for (int i = 0; i < hkq_pkg::SLOTS; i++) begin
                if (take[i] && rank[i] == bank_ofs[b]) begin
                    bank_wdata[b] = xl[i].code;
                end
            end
            bank_re[b]    = do_pop && (r_rd_ptr[2:0] == 3'(b));
        end
    end

    for (genvar b = 0; b < hkq_pkg::BANKS; b++) begin : g_bank
        hkq_ram #(
            .WIDTH (8),
            .DEPTH (ROW_DEPTH)
        ) u_key_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr (bank_waddr[b]),
            .i_wdata (bank_wdata[b]),
            .i_re    (bank_re[b]),
            .i_raddr (r_rd_ptr[PTR_W-1:hkq_pkg::BANK_BITS]),
            .o_rdata (bank_q[b])
        );
    end

    // ---------------- queue and previous-code state ----------------
    logic push_now;

    assign push_now = s1_done && do_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            for (int i = 0; i < hkq_pkg::SLOTS; i++) begin
                r_prev[i] <= 8'h00;
            end
        end else begin
            if (push_now) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(n_push);
                r_count  <= r_count + CNT_W'(n_push);
                for (int i = 0; i < hkq_pkg::SLOTS; i++) begin
                    r_prev[i] <= r_s1_raw[i];
                end
            end else if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                r_count  <= r_count - 1'b1;
            end else if (s1_done && r_s1_kind == hkq_pkg::KIND_UNMOUNT) begin
                for (int i = 0; i < hkq_pkg::SLOTS; i++) begin
                    r_prev[i] <= 8'h00;
                end
            end
        end
    end

    // ---------------- result register ----------------
    logic       r_out_got;
    logic [2:0] r_out_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_done && r_s1_kind == hkq_pkg::KIND_READ) begin
            r_out_valid <= 1'b1;
        end else if (o_key.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done && r_s1_kind == hkq_pkg::KIND_READ) begin
            r_out_got  <= q_nonempty;
            r_out_bank <= r_rd_ptr[2:0];
        end
    end

    // bank read registers hold while the result waits, no new pop is issued
    assign o_key.valid    = r_out_valid;
    assign o_key.got_key  = r_out_got;
    assign o_key.key_code = r_out_got ? bank_q[r_out_bank] : 8'h00;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("key queue over capacity");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == PTR_W'(r_count))
        else $error("queue pointers disagree with fill count");

    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_item.ready)
        else $error("item accepted during map clearing");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && r_s1_kind == hkq_pkg::KIND_READ) |=> r_out_valid)
        else $error("read item gave no result");

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(do_pop && push_now && n_push != 3'd0))
        else $error("push and pop in the same cycle");
`endif

endmodule

`default_nettype wire
